### sv/ffha_pkg.sv
package ffha_pkg;

  localparam int HDR_BYTES  = 16;
  localparam int GRAN_BYTES = 8;

  localparam logic [1:0] TAG_NONE = 2'd0;
  localparam logic [1:0] TAG_USED = 2'd1;
  localparam logic [1:0] TAG_FREE = 2'd2;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_OOM     = 2'd1;
  localparam logic [1:0] ST_BAD     = 2'd2;
  localparam logic [1:0] ST_CORRUPT = 2'd3;

  localparam logic [2:0] ACT_ALLOC   = 3'd0;
  localparam logic [2:0] ACT_FREE    = 3'd1;
  localparam logic [2:0] ACT_REALLOC = 3'd2;
  localparam logic [2:0] ACT_QUERY   = 3'd3;
  localparam logic [2:0] ACT_REINIT  = 3'd4;

  // datapath micro-operations
  localparam logic [4:0] OP_NOP        = 5'd0;
  localparam logic [4:0] OP_CAPTURE    = 5'd1;
  localparam logic [4:0] OP_DISPATCH   = 5'd2;
  localparam logic [4:0] OP_CLR        = 5'd3;
  localparam logic [4:0] OP_INIT       = 5'd4;
  localparam logic [4:0] OP_WALK_RD    = 5'd5;
  localparam logic [4:0] OP_WALK_EV    = 5'd6;
  localparam logic [4:0] OP_SPLIT_HDR  = 5'd7;
  localparam logic [4:0] OP_SPLIT_LINK = 5'd8;
  localparam logic [4:0] OP_ALLOC_FIN  = 5'd9;
  localparam logic [4:0] OP_LOC_RD     = 5'd10;
  localparam logic [4:0] OP_LOC_EV     = 5'd11;
  localparam logic [4:0] OP_KEEP       = 5'd12;
  localparam logic [4:0] OP_FREE_RD    = 5'd13;
  localparam logic [4:0] OP_FREE_MARK  = 5'd14;
  localparam logic [4:0] OP_FREE_NEXT  = 5'd15;
  localparam logic [4:0] OP_FREE_LINK1 = 5'd16;
  localparam logic [4:0] OP_FREE_PREV  = 5'd17;
  localparam logic [4:0] OP_FREE_LINK2 = 5'd18;
  localparam logic [4:0] OP_OUT_LOAD   = 5'd19;

  typedef struct packed {
    logic [4:0] op;
  } dp_cmd_t;

  typedef struct packed {
    logic [2:0] act;
    logic       addr_zero;
    logic       req_zero;
    logic       clr_last;
    logic       ev_corrupt;
    logic       ev_fit;
    logic       ev_split;
    logic       ev_split_bad;
    logic       ev_end;
    logic       loc_ok;
    logic       keep;
    logic       out_hold;
  } dp_stat_t;

endpackage

### sv/ffha_ram.sv
module ffha_ram #(
  parameter int W = 8,
  parameter int D = 16
) (
  input  logic                 clk,
  input  logic                 we,
  input  logic [$clog2(D)-1:0] waddr,
  input  logic [W-1:0]         wdata,
  input  logic [$clog2(D)-1:0] raddr,
  output logic [W-1:0]         rdata
);

  logic [W-1:0] mem [D];
  logic [W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

### sv/ffha_dp.sv
module ffha_dp #(
  parameter int HEAP_BYTES = 65536
) (
  input  logic             clk,
  input  logic             rst_n,
  input  ffha_pkg::dp_cmd_t cmd,
  output ffha_pkg::dp_stat_t stat,
  input  logic [2:0]       in_action,
  input  logic [31:0]      in_req_size,
  input  logic [31:0]      in_user_addr,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [31:0]      cfg_data,
  output logic             out_valid,
  input  logic             out_stall,
  output logic [31:0]      out_addr,
  output logic [15:0]      out_size,
  output logic [1:0]       out_status,
  output logic [15:0]      out_used_total
);

  localparam int SLOTS = HEAP_BYTES / ffha_pkg::GRAN_BYTES;
  localparam int IW    = $clog2(SLOTS);
  localparam int SW    = $clog2(SLOTS * ffha_pkg::GRAN_BYTES);
  localparam int PW    = $clog2(SLOTS + 1);
  localparam int NW    = IW + 2;
  localparam logic [SW-1:0] INIT_SIZE = SW'(SLOTS * ffha_pkg::GRAN_BYTES - ffha_pkg::HDR_BYTES);
  localparam logic [SW-1:0] HDR_SW    = SW'(ffha_pkg::HDR_BYTES);

  logic [31:0]   base_r;
  logic [2:0]    act_r;
  logic [31:0]   req_r;
  logic [31:0]   uaddr_r;
  logic [32:0]   sz_r;
  logic [IW-1:0] i_r, r_r, idx_r, clr_r;
  logic [SW-1:0] bs_r, si_r, used_r, osize_r;
  logic [NW-1:0] a_r;
  logic          a_ok_r, n_ok_r, link_r, loc_in_r;
  logic [PW-1:0] p_r;
  logic [31:0]   oaddr_r;
  logic [1:0]    st_r;
  logic          out_valid_r;
  logic [31:0]   out_addr_r;
  logic [15:0]   out_size_r, out_used_r;
  logic [1:0]    out_status_r;

  logic [1:0]    tag_rd;
  logic [SW-1:0] size_rd;
  logic [PW-1:0] prev_rd;
  logic          tag_we, size_we, prev_we;
  logic [IW-1:0] tag_wa, size_wa, prev_wa, rd_a;
  logic [1:0]    tag_wd;
  logic [SW-1:0] size_wd;
  logic [PW-1:0] prev_wd;

  // address check
  logic [31:0] blk, off;
  logic        loc_in;
  logic [IW-1:0] loc_idx;
  assign blk     = uaddr_r - 32'(ffha_pkg::HDR_BYTES);
  assign off     = blk - base_r;
  assign loc_in  = (blk >= base_r) && (off < 32'(SLOTS * ffha_pkg::GRAN_BYTES))
                   && (off[2:0] == 3'd0);
  assign loc_idx = off[IW+2:3];

  // walk
  logic [NW-1:0] walk_next;
  logic [32:0]   r_wide;
  logic          fit, split, split_bad, walk_end, corrupt;
  assign walk_next = NW'(i_r) + NW'(2) + NW'(size_rd >> 3);
  assign r_wide    = 33'(i_r) + 33'd2 + {3'b000, sz_r[32:3]};
  assign corrupt   = (tag_rd != ffha_pkg::TAG_USED) && (tag_rd != ffha_pkg::TAG_FREE);
  assign fit       = (tag_rd == ffha_pkg::TAG_FREE) && ({17'd0, size_rd} >= 33'(sz_r));
  assign split     = fit && ({18'd0, size_rd} >= ({1'b0, sz_r} + 34'd24));
  assign split_bad = split && (r_wide >= 33'(SLOTS));
  assign walk_end  = walk_next >= NW'(SLOTS);

  // free path
  logic [NW-1:0] fm_n, fn_a, fp_a;
  logic [SW-1:0] fn_size, fp_size;
  logic [IW-1:0] q_idx;
  logic          pv_ok;
  assign fm_n    = NW'(idx_r) + NW'(2) + NW'(size_rd >> 3);
  assign fn_size = si_r + HDR_SW + size_rd;
  assign fn_a    = NW'(idx_r) + NW'(2) + NW'(fn_size >> 3);
  assign q_idx   = IW'(p_r - PW'(1));
  assign pv_ok   = (p_r != '0) && (32'(p_r) - 32'd1 < 32'(SLOTS));
  assign fp_size = size_rd + HDR_SW + si_r;
  assign fp_a    = NW'(q_idx) + NW'(2) + NW'(fp_size >> 3);

  logic [32:0] sz_round;
  assign sz_round = (in_req_size == 32'd0) ? 33'd8 :
                    (({1'b0, in_req_size} + 33'd7) & ~33'd7);

  always_comb begin
    tag_we  = 1'b0;
    size_we = 1'b0;
    prev_we = 1'b0;
    tag_wa  = idx_r;
    size_wa = idx_r;
    prev_wa = idx_r;
    tag_wd  = ffha_pkg::TAG_FREE;
    size_wd = bs_r;
    prev_wd = '0;
    rd_a    = i_r;
    case (cmd.op)
      ffha_pkg::OP_CLR: begin
        tag_we = 1'b1;
        tag_wa = clr_r;
        tag_wd = ffha_pkg::TAG_NONE;
      end
      ffha_pkg::OP_INIT: begin
        tag_we  = 1'b1;
        size_we = 1'b1;
        prev_we = 1'b1;
        tag_wa  = '0;
        size_wa = '0;
        prev_wa = '0;
        size_wd = INIT_SIZE;
      end
      ffha_pkg::OP_WALK_RD: rd_a = i_r;
      ffha_pkg::OP_SPLIT_HDR: begin
        tag_we  = 1'b1;
        size_we = 1'b1;
        prev_we = 1'b1;
        tag_wa  = r_r;
        size_wa = r_r;
        prev_wa = r_r;
        size_wd = bs_r - sz_r[SW-1:0] - HDR_SW;
        prev_wd = PW'(i_r) + PW'(1);
      end
      ffha_pkg::OP_SPLIT_LINK: begin
        prev_we = a_ok_r;
        prev_wa = a_r[IW-1:0];
        prev_wd = PW'(r_r) + PW'(1);
      end
      ffha_pkg::OP_ALLOC_FIN: begin
        tag_we  = 1'b1;
        size_we = 1'b1;
        tag_wa  = i_r;
        size_wa = i_r;
        tag_wd  = ffha_pkg::TAG_USED;
        size_wd = bs_r;
      end
      ffha_pkg::OP_LOC_RD: rd_a = loc_idx;
      ffha_pkg::OP_FREE_RD: rd_a = idx_r;
      ffha_pkg::OP_FREE_MARK: begin
        tag_we = 1'b1;
        tag_wa = idx_r;
        tag_wd = ffha_pkg::TAG_FREE;
        rd_a   = fm_n[IW-1:0];
      end
      ffha_pkg::OP_FREE_NEXT: begin
        size_we = n_ok_r && (tag_rd == ffha_pkg::TAG_FREE);
        size_wa = idx_r;
        size_wd = fn_size;
      end
      ffha_pkg::OP_FREE_LINK1: begin
        prev_we = link_r;
        prev_wa = a_r[IW-1:0];
        prev_wd = PW'(idx_r) + PW'(1);
        rd_a    = q_idx;
      end
      ffha_pkg::OP_FREE_PREV: begin
        size_we = n_ok_r && (tag_rd == ffha_pkg::TAG_FREE);
        size_wa = q_idx;
        size_wd = fp_size;
      end
      ffha_pkg::OP_FREE_LINK2: begin
        prev_we = link_r;
        prev_wa = a_r[IW-1:0];
        prev_wd = p_r;
      end
      default: ;
    endcase
  end

  ffha_ram #(.W(2), .D(SLOTS)) u_tag (
    .clk(clk), .we(tag_we), .waddr(tag_wa), .wdata(tag_wd), .raddr(rd_a), .rdata(tag_rd)
  );
  ffha_ram #(.W(SW), .D(SLOTS)) u_size (
    .clk(clk), .we(size_we), .waddr(size_wa), .wdata(size_wd), .raddr(rd_a),
    .rdata(size_rd)
  );
  ffha_ram #(.W(PW), .D(SLOTS)) u_prev (
    .clk(clk), .we(prev_we), .waddr(prev_wa), .wdata(prev_wd), .raddr(rd_a),
    .rdata(prev_rd)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_r      <= '0;
      clr_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_valid) begin
        base_r <= cfg_data;
      end
      if (cmd.op == ffha_pkg::OP_OUT_LOAD) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
      if (cmd.op == ffha_pkg::OP_CLR) begin
        clr_r <= (32'(clr_r) == SLOTS - 1) ? '0 : clr_r + IW'(1);
      end
    end

    case (cmd.op)
      ffha_pkg::OP_CAPTURE: begin
        act_r   <= in_action;
        req_r   <= in_req_size;
        uaddr_r <= in_user_addr;
        sz_r    <= sz_round;
        i_r     <= '0;
        oaddr_r <= '0;
        osize_r <= '0;
        st_r    <= ffha_pkg::ST_OK;
      end
      ffha_pkg::OP_DISPATCH: begin
        if ((act_r == ffha_pkg::ACT_QUERY) && (uaddr_r == 32'd0)) begin
          st_r <= ffha_pkg::ST_BAD;
        end
      end
      ffha_pkg::OP_INIT: used_r <= '0;
      ffha_pkg::OP_WALK_EV: begin
        bs_r   <= size_rd;
        r_r    <= r_wide[IW-1:0];
        a_r    <= walk_next;
        a_ok_r <= !walk_end;
        if (corrupt || split_bad) begin
          st_r <= ffha_pkg::ST_CORRUPT;
        end else if (!fit && walk_end) begin
          st_r <= ffha_pkg::ST_OOM;
        end else if (!fit) begin
          i_r <= walk_next[IW-1:0];
        end
      end
      ffha_pkg::OP_SPLIT_HDR: bs_r <= sz_r[SW-1:0];
      ffha_pkg::OP_ALLOC_FIN: begin
        used_r  <= used_r + bs_r;
        oaddr_r <= base_r + {{(29-IW){1'b0}}, i_r, 3'b000} + 32'(ffha_pkg::HDR_BYTES);
        osize_r <= bs_r;
      end
      ffha_pkg::OP_LOC_RD: begin
        idx_r    <= loc_idx;
        loc_in_r <= loc_in;
      end
      ffha_pkg::OP_LOC_EV: begin
        bs_r <= size_rd;
        if (!(loc_in_r && (tag_rd == ffha_pkg::TAG_USED))) begin
          st_r <= ffha_pkg::ST_BAD;
        end
      end
      ffha_pkg::OP_KEEP: begin
        oaddr_r <= uaddr_r;
        osize_r <= bs_r;
      end
      ffha_pkg::OP_FREE_MARK: begin
        si_r   <= size_rd;
        p_r    <= prev_rd;
        used_r <= (size_rd <= used_r) ? used_r - size_rd : '0;
        n_ok_r <= fm_n < NW'(SLOTS);
      end
      ffha_pkg::OP_FREE_NEXT: begin
        if (n_ok_r && (tag_rd == ffha_pkg::TAG_FREE)) begin
          si_r   <= fn_size;
          a_r    <= fn_a;
          link_r <= fn_a < NW'(SLOTS);
        end else begin
          link_r <= 1'b0;
        end
      end
      ffha_pkg::OP_FREE_LINK1: n_ok_r <= pv_ok;
      ffha_pkg::OP_FREE_PREV: begin
        if (n_ok_r && (tag_rd == ffha_pkg::TAG_FREE)) begin
          a_r    <= fp_a;
          link_r <= fp_a < NW'(SLOTS);
        end else begin
          link_r <= 1'b0;
        end
      end
      ffha_pkg::OP_OUT_LOAD: begin
        out_addr_r   <= oaddr_r;
        out_size_r   <= 16'(32'(osize_r));
        out_status_r <= st_r;
        out_used_r   <= 16'(32'(used_r));
      end
      default: ;
    endcase
  end

  always_comb begin
    stat.act          = act_r;
    stat.addr_zero    = uaddr_r == 32'd0;
    stat.req_zero     = req_r == 32'd0;
    stat.clr_last     = 32'(clr_r) == SLOTS - 1;
    stat.ev_corrupt   = corrupt;
    stat.ev_fit       = fit;
    stat.ev_split     = split;
    stat.ev_split_bad = split_bad;
    stat.ev_end       = walk_end;
    stat.loc_ok       = loc_in_r && (tag_rd == ffha_pkg::TAG_USED);
    stat.keep         = req_r <= {{(32-SW){1'b0}}, size_rd};
    stat.out_hold     = out_valid_r && out_stall;
  end

  assign cfg_ready      = 1'b1;
  assign out_valid      = out_valid_r;
  assign out_addr       = out_addr_r;
  assign out_size       = out_size_r;
  assign out_status     = out_status_r;
  assign out_used_total = out_used_r;

endmodule

### sv/ffha_ctrl.sv
module ffha_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  ffha_pkg::dp_stat_t stat,
  output ffha_pkg::dp_cmd_t  cmd
);

  localparam logic [4:0] S_CLR        = 5'd0;
  localparam logic [4:0] S_INIT       = 5'd1;
  localparam logic [4:0] S_IDLE       = 5'd2;
  localparam logic [4:0] S_DISPATCH   = 5'd3;
  localparam logic [4:0] S_WALK_RD    = 5'd4;
  localparam logic [4:0] S_WALK_EV    = 5'd5;
  localparam logic [4:0] S_SPLIT_HDR  = 5'd6;
  localparam logic [4:0] S_SPLIT_LINK = 5'd7;
  localparam logic [4:0] S_ALLOC_FIN  = 5'd8;
  localparam logic [4:0] S_LOC_RD     = 5'd9;
  localparam logic [4:0] S_LOC_EV     = 5'd10;
  localparam logic [4:0] S_KEEP       = 5'd11;
  localparam logic [4:0] S_FREE_RD    = 5'd12;
  localparam logic [4:0] S_FREE_MARK  = 5'd13;
  localparam logic [4:0] S_FREE_NEXT  = 5'd14;
  localparam logic [4:0] S_FREE_LINK1 = 5'd15;
  localparam logic [4:0] S_FREE_PREV  = 5'd16;
  localparam logic [4:0] S_FREE_LINK2 = 5'd17;
  localparam logic [4:0] S_DONE       = 5'd18;

  logic [4:0] state_r, state_nxt;
  logic       boot_r, boot_nxt;
  logic       re_r, re_nxt;

  always_comb begin
    state_nxt = state_r;
    boot_nxt  = boot_r;
    re_nxt    = re_r;
    cmd.op    = ffha_pkg::OP_NOP;
    case (state_r)
      S_CLR: begin
        cmd.op = ffha_pkg::OP_CLR;
        if (stat.clr_last) state_nxt = S_INIT;
      end
      S_INIT: begin
        cmd.op    = ffha_pkg::OP_INIT;
        state_nxt = boot_r ? S_IDLE : S_DONE;
        boot_nxt  = 1'b0;
      end
      S_IDLE: begin
        if (in_valid) begin
          cmd.op    = ffha_pkg::OP_CAPTURE;
          state_nxt = S_DISPATCH;
          re_nxt    = 1'b0;
        end
      end
      S_DISPATCH: begin
        cmd.op = ffha_pkg::OP_DISPATCH;
        case (stat.act)
          ffha_pkg::ACT_ALLOC:   state_nxt = S_WALK_RD;
          ffha_pkg::ACT_FREE:    state_nxt = stat.addr_zero ? S_DONE : S_LOC_RD;
          ffha_pkg::ACT_REALLOC: state_nxt = stat.addr_zero ? S_WALK_RD : S_LOC_RD;
          ffha_pkg::ACT_QUERY:   state_nxt = stat.addr_zero ? S_DONE : S_LOC_RD;
          ffha_pkg::ACT_REINIT:  state_nxt = S_CLR;
          default:               state_nxt = S_DONE;
        endcase
      end
      S_WALK_RD: begin
        cmd.op    = ffha_pkg::OP_WALK_RD;
        state_nxt = S_WALK_EV;
      end
      S_WALK_EV: begin
        cmd.op = ffha_pkg::OP_WALK_EV;
        if (stat.ev_corrupt || stat.ev_split_bad) begin
          state_nxt = S_DONE;
        end else if (stat.ev_split) begin
          state_nxt = S_SPLIT_HDR;
        end else if (stat.ev_fit) begin
          state_nxt = S_ALLOC_FIN;
        end else if (stat.ev_end) begin
          state_nxt = S_DONE;
        end else begin
          state_nxt = S_WALK_RD;
        end
      end
      S_SPLIT_HDR: begin
        cmd.op    = ffha_pkg::OP_SPLIT_HDR;
        state_nxt = S_SPLIT_LINK;
      end
      S_SPLIT_LINK: begin
        cmd.op    = ffha_pkg::OP_SPLIT_LINK;
        state_nxt = S_ALLOC_FIN;
      end
      S_ALLOC_FIN: begin
        cmd.op    = ffha_pkg::OP_ALLOC_FIN;
        state_nxt = re_r ? S_FREE_RD : S_DONE;
      end
      S_LOC_RD: begin
        cmd.op    = ffha_pkg::OP_LOC_RD;
        state_nxt = S_LOC_EV;
      end
      S_LOC_EV: begin
        cmd.op = ffha_pkg::OP_LOC_EV;
        if (!stat.loc_ok) begin
          state_nxt = S_DONE;
        end else if (stat.act == ffha_pkg::ACT_FREE) begin
          state_nxt = S_FREE_RD;
        end else if (stat.act == ffha_pkg::ACT_QUERY) begin
          state_nxt = S_KEEP;
        end else if (stat.req_zero) begin
          state_nxt = S_FREE_RD;
        end else if (stat.keep) begin
          state_nxt = S_KEEP;
        end else begin
          state_nxt = S_WALK_RD;
          re_nxt    = 1'b1;
        end
      end
      S_KEEP: begin
        cmd.op    = ffha_pkg::OP_KEEP;
        state_nxt = S_DONE;
      end
      S_FREE_RD: begin
        cmd.op    = ffha_pkg::OP_FREE_RD;
        state_nxt = S_FREE_MARK;
      end
      S_FREE_MARK: begin
        cmd.op    = ffha_pkg::OP_FREE_MARK;
        state_nxt = S_FREE_NEXT;
      end
      S_FREE_NEXT: begin
        cmd.op    = ffha_pkg::OP_FREE_NEXT;
        state_nxt = S_FREE_LINK1;
      end
      S_FREE_LINK1: begin
        cmd.op    = ffha_pkg::OP_FREE_LINK1;
        state_nxt = S_FREE_PREV;
      end
      S_FREE_PREV: begin
        cmd.op    = ffha_pkg::OP_FREE_PREV;
        state_nxt = S_FREE_LINK2;
      end
      S_FREE_LINK2: begin
        cmd.op    = ffha_pkg::OP_FREE_LINK2;
        state_nxt = S_DONE;
      end
      S_DONE: begin
        if (!stat.out_hold) begin
          cmd.op    = ffha_pkg::OP_OUT_LOAD;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_CLR;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLR;
      boot_r  <= 1'b1;
      re_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      boot_r  <= boot_nxt;
      re_r    <= re_nxt;
    end
  end

  assign in_stall = state_r != S_IDLE;

endmodule

### sv/first_fit_heap_allocator.sv
// Flow, request transfer to out_valid: free of zero and unknown actions go straight
//   to the result; alloc walks headers (one tag/size read and compare per block)
//   and may split; free of a live block and query first locate it; realloc runs
//   up to locate + alloc + free. Reinitialize clears every tag first.
// Throughput: one transfer at a time; the next item is taken once the result
//   sits in the output register, even while that result is still stalled.
// Reset: synchronous rst_n; afterwards a tag clearing pass over all HEAP_BYTES/8
//   slots runs with in_stall high, then slot zero becomes one free block.
module first_fit_heap_allocator #(
  parameter int HEAP_BYTES = 65536
) (
  input  logic        clk,
  input  logic        rst_n,
  // request channel
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [2:0]  in_action,
  input  logic [31:0] in_req_size,
  input  logic [31:0] in_user_addr,
  // heap base register
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [31:0] cfg_data,
  // result channel
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] out_addr,
  output logic [15:0] out_size,
  output logic [1:0]  out_status,
  output logic [15:0] out_used_total
);

  // controller sequences micro-ops; datapath owns the header stores
  ffha_pkg::dp_cmd_t  cmd;
  ffha_pkg::dp_stat_t stat;

  ffha_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .stat     (stat),
    .cmd      (cmd)
  );

  // header stores: tag, usable size, previous slot plus one
  ffha_dp #(.HEAP_BYTES(HEAP_BYTES)) u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .stat           (stat),
    .in_action      (in_action),
    .in_req_size    (in_req_size),
    .in_user_addr   (in_user_addr),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_data       (cfg_data),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_addr       (out_addr),
    .out_size       (out_size),
    .out_status     (out_status),
    .out_used_total (out_used_total)
  );

endmodule
